// ===== src/ocop_pkg.sv =====
// Shared types, constants and helper functions for the orbit camera projector.
// Used by ocop_basis, orbit_camera_ortho_projection and ocop_checker.
package ocop_pkg;

	// configuration register indexes
	localparam logic [1:0] IDX_AZ  = 2'd0;
	localparam logic [1:0] IDX_EL  = 2'd1;
	localparam logic [1:0] IDX_MHW = 2'd2;

	localparam int TURN         = 46080;
	localparam int HALF_TURN    = 23040;
	localparam int QUARTER_TURN = 11520;

	localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
	localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;
	localparam logic signed [31:0] DEG_PER_RAD_Q22 = 32'sd240315917;

	typedef enum logic [1:0] {
		TRIG_CORDIC = 2'd0,
		TRIG_ZERO   = 2'd1,
		TRIG_POS90  = 2'd2,
		TRIG_NEG90  = 2'd3
	} trig_spec_t;

	typedef struct packed {
		logic signed [31:0] z;
		logic               flip;
		trig_spec_t         spec;
	} angle_red_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] c;
	} sincos_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [31:0] data;
	} ocop_cfg_t;

	// right vector (z component is always zero) and up vector, Q2.30
	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
	} ocop_basis_t;

	// CORDIC rotation angle per step, 2^-22 degree
	function automatic logic signed [31:0] atan_step(input logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0: v = 32'sd188743680;
			5'd1: v = 32'sd111421900;
			5'd2: v = 32'sd58872272;
			5'd3: v = 32'sd29884485;
			5'd4: v = 32'sd15000234;
			5'd5: v = 32'sd7507429;
			5'd6: v = 32'sd3754631;
			5'd7: v = 32'sd1877430;
			5'd8: v = 32'sd938729;
			5'd9: v = 32'sd469366;
			default: v = DEG_PER_RAD_Q22 >>> i;
		endcase
		return v;
	endfunction

	// fold an angle into +-90 degrees, flag exact cases
	function automatic angle_red_t reduce_angle(input logic signed [16:0] a);
		angle_red_t o;
		logic signed [17:0] r;
		r = 18'(a);
		if (r >= TURN) begin
			r = 18'(r - TURN);
		end else if (r <= -TURN) begin
			r = 18'(r + TURN);
		end
		if (r < -HALF_TURN) r = 18'(r + TURN);
		if (r >= HALF_TURN) r = 18'(r - TURN);
		o.flip = 1'b0;
		if (r > QUARTER_TURN) begin
			r = 18'(r - HALF_TURN);
			o.flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r = 18'(r + HALF_TURN);
			o.flip = 1'b1;
		end
		if (r == 0) o.spec = TRIG_ZERO;
		else if (r == QUARTER_TURN) o.spec = TRIG_POS90;
		else if (r == -QUARTER_TURN) o.spec = TRIG_NEG90;
		else o.spec = TRIG_CORDIC;
		o.z = 32'(r) <<< 15;
		return o;
	endfunction

	function automatic sincos_t trig_out(input logic signed [33:0] x, input logic signed [33:0] y,
		input trig_spec_t spec, input logic flip);
		sincos_t o;
		logic signed [31:0] c;
		logic signed [31:0] s;
		case (spec)
			TRIG_ZERO:  begin c = ONE_Q30; s = '0; end
			TRIG_POS90: begin c = '0; s = ONE_Q30; end
			TRIG_NEG90: begin c = '0; s = -ONE_Q30; end
			default:    begin c = 32'(x); s = 32'(y); end
		endcase
		if (flip) begin
			c = -c;
			s = -s;
		end
		o.c = c;
		o.s = s;
		return o;
	endfunction

endpackage

// ===== src/ocop_basis.sv =====
// Screen basis builder: CORDIC sin/cos, shared multiplier, bit-serial isqrt and divider.
// Depends on ocop_pkg.
module ocop_basis import ocop_pkg::*; #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ocop_cfg_t   cfg,
	output logic        busy,
	output ocop_basis_t basis
);

	localparam int ITER_W = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(TRIG_ITERATIONS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_TRIG = 7'b0000010,
		ST_CAM  = 7'b0000100,
		ST_SQ   = 7'b0001000,
		ST_SQRT = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_UP   = 7'b1000000
	} bstate_t;

	bstate_t state_q;
	logic [ITER_W-1:0] iter_q;
	logic [4:0] step_q;
	logic [1:0] sel_q;
	logic phase_q;

	logic signed [16:0] azim_q;
	logic signed [14:0] elev_q;

	logic signed [33:0] ax_q, ay_q, ex_q, ey_q;
	logic signed [31:0] azz_q, ezz_q;
	trig_spec_t a_spec_q, e_spec_q;
	logic a_flip_q, e_flip_q;

	logic signed [31:0] cx_q, cy_q, cz_q, ut_q;
	logic signed [31:0] rx_q, ry_q, ux_q, uy_q, uz_q;
	logic [63:0] acc_q, root_q, rem_q;
	logic [31:0] len_q;
	logic [30:0] quo_q;

	logic wr_az, wr_el, start;
	logic signed [16:0] new_az;
	logic signed [14:0] new_el;
	angle_red_t red_a, red_e;
	sincos_t sc_a, sc_e;
	logic signed [31:0] mul_a, mul_b, mq;
	logic signed [63:0] prod, rnd;
	logic [63:0] sq_b, sq_rb, root_nx, acc_nx, div_t;
	logic sq_take, div_take, step_end, last_sel;
	logic [31:0] quo_full, nxt_mag;
	logic signed [31:0] cur_num, nxt_num, qs;
	logic [1:0] nsel;
	logic [4:0] iter5;
	logic signed [33:0] adx, ady, edx, edy;

	function automatic logic signed [31:0] pick(input logic ph, input logic [1:0] s,
		input logic signed [31:0] vx, input logic signed [31:0] vy, input logic signed [31:0] vz,
		input logic signed [31:0] wx, input logic signed [31:0] wy);
		logic signed [31:0] v;
		case ({ph, s})
			3'b000: v = vx;
			3'b001: v = vy;
			3'b010: v = vz;
			3'b100: v = wx;
			3'b101: v = wy;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign wr_az  = cfg.we && (cfg.index == IDX_AZ);
	assign wr_el  = cfg.we && (cfg.index == IDX_EL);
	assign start  = wr_az || wr_el;
	assign new_az = wr_az ? $signed(cfg.data[16:0]) : azim_q;
	assign new_el = wr_el ? $signed(cfg.data[14:0]) : elev_q;
	assign red_a  = reduce_angle(new_az);
	assign red_e  = reduce_angle(17'(new_el));

	assign sc_a = trig_out(ax_q, ay_q, a_spec_q, a_flip_q);
	assign sc_e = trig_out(ex_q, ey_q, e_spec_q, e_flip_q);

	assign iter5 = 5'(iter_q);
	assign adx = ay_q >>> iter_q;
	assign ady = ax_q >>> iter_q;
	assign edx = ey_q >>> iter_q;
	assign edy = ex_q >>> iter_q;

	assign cur_num = pick(phase_q, sel_q, cx_q, cy_q, cz_q, rx_q, ry_q);
	assign nsel    = (state_q == ST_SQRT) ? 2'd0 : 2'(sel_q + 2'd1);
	assign nxt_num = pick(phase_q, nsel, cx_q, cy_q, cz_q, rx_q, ry_q);
	assign nxt_mag = nxt_num[31] ? 32'(-nxt_num) : 32'(nxt_num);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CAM: begin
				mul_a = sc_e.c;
				mul_b = (sel_q == 2'd0) ? sc_a.c : sc_a.s;
			end
			ST_SQ: begin
				mul_a = cur_num;
				mul_b = cur_num;
			end
			ST_UP: begin
				case (sel_q)
					2'd0: begin mul_a = cz_q; mul_b = ry_q; end
					2'd1: begin mul_a = cz_q; mul_b = rx_q; end
					2'd2: begin mul_a = cx_q; mul_b = ry_q; end
					default: begin mul_a = cy_q; mul_b = rx_q; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign rnd  = prod + 64'sd536870912;
	assign mq   = rnd[61:30];

	// one root bit per cycle
	assign sq_b    = 64'd1 << {~step_q, 1'b0};
	assign sq_rb   = root_q + sq_b;
	assign sq_take = acc_q >= sq_rb;
	assign root_nx = sq_take ? ((root_q >> 1) + sq_b) : (root_q >> 1);
	assign acc_nx  = sq_take ? (acc_q - sq_rb) : acc_q;

	// one quotient bit per cycle, msb first
	assign div_t    = 64'(len_q) << (~step_q);
	assign div_take = rem_q >= div_t;
	assign quo_full = {quo_q, div_take};
	assign qs       = cur_num[31] ? $signed(32'(32'd0 - quo_full)) : $signed(quo_full);

	assign step_end = (step_q == 5'd31);
	assign last_sel = phase_q ? (sel_q == 2'd1) : (sel_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			step_q  <= '0;
			sel_q   <= '0;
			phase_q <= 1'b0;
			azim_q  <= '0;
			elev_q  <= '0;
			rx_q    <= '0;
			ry_q    <= ONE_Q30;
			ux_q    <= '0;
			uy_q    <= '0;
			uz_q    <= ONE_Q30;
		end else begin
			if (wr_az) azim_q <= new_az;
			if (wr_el) elev_q <= new_el;
			if (start) begin
				// a new angle restarts the rebuild from the top
				state_q <= ST_TRIG;
				iter_q  <= '0;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_TRIG: begin
						iter_q <= ITER_W'(iter_q + 1'b1);
						if (iter_q == ITER_LAST) begin
							state_q <= ST_CAM;
							sel_q   <= '0;
						end
					end
					ST_CAM: begin
						if (sel_q == 2'd1) begin
							state_q <= ST_SQ;
							sel_q   <= '0;
							phase_q <= 1'b0;
						end else begin
							sel_q <= 2'(sel_q + 2'd1);
						end
					end
					ST_SQ: begin
						if (last_sel) begin
							state_q <= ST_SQRT;
							step_q  <= '0;
						end else begin
							sel_q <= 2'(sel_q + 2'd1);
						end
					end
					ST_SQRT: begin
						step_q <= 5'(step_q + 5'd1);
						if (step_end) begin
							sel_q <= '0;
							if (root_nx == '0) begin
								// degenerate length: fixed fallback vectors
								if (!phase_q) begin
									rx_q    <= '0;
									ry_q    <= '0;
									state_q <= ST_SQ;
									phase_q <= 1'b1;
								end else begin
									rx_q    <= ONE_Q30;
									ry_q    <= '0;
									state_q <= ST_UP;
								end
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
					ST_DIV: begin
						step_q <= 5'(step_q + 5'd1);
						if (step_end) begin
							if (phase_q) begin
								if (sel_q == 2'd0) rx_q <= qs;
								else ry_q <= qs;
							end
							if (last_sel) begin
								sel_q <= '0;
								if (!phase_q) begin
									// right = z-hat cross camera
									rx_q    <= -cy_q;
									ry_q    <= cx_q;
									phase_q <= 1'b1;
									state_q <= ST_SQ;
								end else begin
									state_q <= ST_UP;
								end
							end else begin
								sel_q <= 2'(sel_q + 2'd1);
							end
						end
					end
					ST_UP: begin
						sel_q <= 2'(sel_q + 2'd1);
						case (sel_q)
							2'd0: ux_q <= -mq;
							2'd1: uy_q <= mq;
							2'd2: ;
							default: begin
								uz_q    <= ut_q - mq;
								state_q <= ST_IDLE;
							end
						endcase
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			ax_q     <= GAIN_INV_Q30;
			ay_q     <= '0;
			azz_q    <= red_a.z;
			a_spec_q <= red_a.spec;
			a_flip_q <= red_a.flip;
			ex_q     <= GAIN_INV_Q30;
			ey_q     <= '0;
			ezz_q    <= red_e.z;
			e_spec_q <= red_e.spec;
			e_flip_q <= red_e.flip;
		end else begin
			case (state_q)
				ST_TRIG: begin
					if (azz_q >= 0) begin
						ax_q  <= ax_q - adx;
						ay_q  <= ay_q + ady;
						azz_q <= azz_q - atan_step(iter5);
					end else begin
						ax_q  <= ax_q + adx;
						ay_q  <= ay_q - ady;
						azz_q <= azz_q + atan_step(iter5);
					end
					if (ezz_q >= 0) begin
						ex_q  <= ex_q - edx;
						ey_q  <= ey_q + edy;
						ezz_q <= ezz_q - atan_step(iter5);
					end else begin
						ex_q  <= ex_q + edx;
						ey_q  <= ey_q - edy;
						ezz_q <= ezz_q + atan_step(iter5);
					end
				end
				ST_CAM: begin
					if (sel_q == 2'd0) begin
						cx_q <= mq;
						cz_q <= sc_e.s;
					end else begin
						cy_q <= mq;
					end
				end
				ST_SQ: begin
					acc_q  <= ((sel_q == 2'd0) ? 64'd0 : acc_q) + 64'(prod);
					root_q <= '0;
				end
				ST_SQRT: begin
					acc_q  <= acc_nx;
					root_q <= root_nx;
					if (step_end) begin
						len_q <= root_nx[31:0];
						rem_q <= 64'(nxt_mag) << 30;
						quo_q <= '0;
						if ((root_nx == '0) && !phase_q) begin
							cx_q <= '0;
							cy_q <= '0;
							cz_q <= ONE_Q30;
						end
					end
				end
				ST_DIV: begin
					if (step_end) begin
						rem_q <= 64'(nxt_mag) << 30;
						quo_q <= '0;
						if (!phase_q) begin
							case (sel_q)
								2'd0: cx_q <= qs;
								2'd1: cy_q <= qs;
								default: cz_q <= qs;
							endcase
						end
					end else begin
						rem_q <= div_take ? (rem_q - div_t) : rem_q;
						quo_q <= quo_full[30:0];
					end
				end
				ST_UP: begin
					if (sel_q == 2'd2) ut_q <= mq;
				end
				default: ;
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign basis.rx = rx_q;
	assign basis.ry = ry_q;
	assign basis.ux = ux_q;
	assign basis.uy = uy_q;
	assign basis.uz = uz_q;

endmodule

// ===== src/orbit_camera_ortho_projection.sv =====
// Orbit camera orthographic projector, top level: point pipeline and running half-width.
// Depends on ocop_pkg and ocop_basis.
//
// Usage:
//  - Config port (cfg_we, cfg_index, cfg_data): index 0 azimuth, 1 elevation (both in
//    1/128 degree), 2 minimum half-width (Q16.16, zero or below turns fitting off).
//    Write only while no item is in flight.
//  - Any angle write starts a basis rebuild: CORDIC for both angles (one step per cycle),
//    then a shared multiplier, a bit-serial square root and a bit-serial divider.
//    The rebuild finishes sooner at the poles, and point_stall stays high for all of it,
//    starting in the cycle of the write. Another angle write during a rebuild restarts it.
//  - Point channel (point_valid/point_stall): x, y, z in Q16.16 and a restart flag that
//    resets the running half-width to the minimum before this point.
//  - Screen channel (screen_valid/screen_stall): screen_x, screen_y and the running
//    half-width including this point. One result per point, in order.
//  - Throughput: one item per cycle when not stalled. Registers from acceptance to screen_valid:
//    input register, product register, sum and saturate register, output register.
//  - Stall: each stage holds while the next one is full and held, so bubbles close up, and
//    back-pressure raises point_stall only once all stages are full behind a stalled result.
//  - Reset: basis for zero angles (right +y, up +z), minimum half-width 1.0, pipeline empty.
module orbit_camera_ortho_projection import ocop_pkg::*; #(
	parameter int COORD_WIDTH     = 32,
	parameter int FRAC_BITS       = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic                          restart,
	output logic                          screen_valid,
	input  logic                          screen_stall,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic signed [COORD_WIDTH-1:0] half_width
);

	localparam int CW    = COORD_WIDTH;
	localparam int PW    = CW + 32;  // product width
	localparam int SW    = PW + 2;   // three-term sum
	localparam int TW    = SW - 30;  // sum after the Q30 shift
	localparam int LIM_W = (CW > 32) ? CW : 32;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [31:0]   MHW_RST = 32'(1 << FRAC_BITS);
	localparam logic signed [CW-1:0] RH_RST  =
		(FRAC_BITS <= COORD_WIDTH - 2) ? CW'(MHW_RST) : CMAX;
	localparam logic signed [SW-1:0] RND = SW'(1 << 29);

	function automatic logic signed [CW-1:0] sat_abs(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		if (!v[CW-1]) r = v;
		else if (v == CMIN) r = CMAX;
		else r = -v;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat_shift(input logic signed [SW-1:0] s);
		logic signed [TW-1:0] t;
		logic signed [CW-1:0] r;
		t = s[SW-1:30];
		if (t > TW'(CMAX)) r = CMAX;
		else if (t < TW'(CMIN)) r = CMIN;
		else r = CW'(t);
		return r;
	endfunction

	ocop_cfg_t   cfg;
	ocop_basis_t basis;
	logic        basis_busy;

	logic signed [31:0]   mhw_q;
	logic signed [CW-1:0] rh_q;
	logic signed [LIM_W-1:0] mhw_ext;
	logic signed [CW-1:0] lim;

	// pipeline
	logic v_s1, v_s2, v_s3, ov_q;
	logic adv_1, adv_2, adv_3, adv_o, ang_wr, acc_in;
	logic signed [CW-1:0] px_s1, py_s1, pz_s1;
	logic r_s1, r_s2, r_s3;
	logic signed [PW-1:0] pxr_s2, pyr_s2, pxu_s2, pyu_s2, pzu_s2;
	logic signed [CW-1:0] sx_s3, sy_s3;
	logic signed [CW-1:0] sx_q, sy_q, hw_q;
	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [CW-1:0] rh_base, rh_nx, abs_x, abs_y;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	ocop_basis #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_basis (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.busy  (basis_busy),
		.basis (basis)
	);

	// minimum half-width, clamped to coordinate range
	assign mhw_ext = LIM_W'(mhw_q);
	always_comb begin
		if (mhw_ext > LIM_W'(CMAX)) lim = CMAX;
		else if (mhw_ext < LIM_W'(CMIN)) lim = CMIN;
		else lim = CW'(mhw_ext);
	end

	// stall chain: each stage advances when the next has room
	assign adv_o  = !ov_q || !screen_stall;
	assign adv_3  = !v_s3 || adv_o;
	assign adv_2  = !v_s2 || adv_3;
	assign adv_1  = !v_s1 || adv_2;
	assign ang_wr = cfg_we && ((cfg_index == IDX_AZ) || (cfg_index == IDX_EL));
	assign point_stall = basis_busy || ang_wr || !adv_1;
	assign acc_in = point_valid && !point_stall;

	assign sum_x = SW'(pxr_s2) + SW'(pyr_s2) + RND;
	assign sum_y = SW'(pxu_s2) + SW'(pyu_s2) + SW'(pzu_s2) + RND;

	// running half-width: max of base, minimum and both screen magnitudes; the minimum itself when it is not positive
	assign abs_x   = sat_abs(sx_s3);
	assign abs_y   = sat_abs(sy_s3);
	assign rh_base = r_s3 ? lim : rh_q;
	always_comb begin
		rh_nx = rh_base;
		if (lim > rh_nx) rh_nx = lim;
		if (abs_x > rh_nx) rh_nx = abs_x;
		if (abs_y > rh_nx) rh_nx = abs_y;
		if (!(lim > 0)) rh_nx = lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			ov_q  <= 1'b0;
			mhw_q <= MHW_RST;
			rh_q  <= RH_RST;
		end else begin
			if (cfg_we && (cfg_index == IDX_MHW)) mhw_q <= $signed(cfg_data);
			if (adv_1) v_s1 <= acc_in;
			if (adv_2) v_s2 <= v_s1;
			if (adv_3) v_s3 <= v_s2;
			if (adv_o) ov_q <= v_s3;
			if (v_s3 && adv_o) rh_q <= rh_nx;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
			pz_s1 <= point_z;
			r_s1  <= restart;
		end
		if (v_s1 && adv_2) begin
			pxr_s2 <= px_s1 * basis.rx;
			pyr_s2 <= py_s1 * basis.ry;
			pxu_s2 <= px_s1 * basis.ux;
			pyu_s2 <= py_s1 * basis.uy;
			pzu_s2 <= pz_s1 * basis.uz;
			r_s2   <= r_s1;
		end
		if (v_s2 && adv_3) begin
			sx_s3 <= sat_shift(sum_x);
			sy_s3 <= sat_shift(sum_y);
			r_s3  <= r_s2;
		end
		if (v_s3 && adv_o) begin
			sx_q <= sx_s3;
			sy_q <= sy_s3;
			hw_q <= rh_nx;
		end
	end

	assign screen_valid = ov_q;
	assign screen_x     = sx_q;
	assign screen_y     = sy_q;
	assign half_width   = hw_q;

endmodule

// ===== src/ocop_checker.sv =====
// Port-level checks for the orbit camera projector, bound to the top level.
// Depends on ocop_pkg.
module ocop_checker import ocop_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [1:0]                    cfg_index,
	input logic                          point_stall,
	input logic                          screen_valid,
	input logic                          screen_stall,
	input logic signed [COORD_WIDTH-1:0] screen_x,
	input logic signed [COORD_WIDTH-1:0] screen_y,
	input logic signed [COORD_WIDTH-1:0] half_width
);

	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [COORD_WIDTH-1:0] abs_x, abs_y;

	assign abs_x = !screen_x[COORD_WIDTH-1] ? screen_x : ((screen_x == CMIN) ? CMAX : -screen_x);
	assign abs_y = !screen_y[COORD_WIDTH-1] ? screen_y : ((screen_y == CMIN) ? CMAX : -screen_y);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && screen_stall |=> screen_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && screen_stall |=>
			$stable(screen_x) && $stable(screen_y) && $stable(half_width))
		else $error("stalled result changed");

	a_rebuild_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && ((cfg_index == IDX_AZ) || (cfg_index == IDX_EL)) |=> point_stall)
		else $error("point taken during basis rebuild");

	a_fit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && (half_width > 0) |-> (half_width >= abs_x) && (half_width >= abs_y))
		else $error("half-width smaller than a screen coordinate");

endmodule

bind orbit_camera_ortho_projection ocop_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_ocop_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.point_stall (point_stall),
	.screen_valid(screen_valid),
	.screen_stall(screen_stall),
	.screen_x    (screen_x),
	.screen_y    (screen_y),
	.half_width  (half_width)
);
